// ===== sv/des_ks_pkg.sv =====
// ----------------------------------------------------------------------------
// DES key schedule package
// Permuted choice tables, rotation schedule and the bit selection functions.
// ----------------------------------------------------------------------------
`default_nettype none

package des_ks_pkg;

    localparam int KEY_W    = 64;
    localparam int HALF_W   = 28;
    localparam int CD_W     = 2 * HALF_W;
    localparam int SUBKEY_W = 48;
    localparam int ROUNDS   = 16;
    localparam int ROUND_W  = $clog2(ROUNDS);

    typedef logic [HALF_W-1:0]   t_half;
    typedef logic [SUBKEY_W-1:0] t_subkey;
    typedef logic [ROUND_W-1:0]  t_round;

    // 1-based DES bit positions, bit 1 is the msb
    localparam byte unsigned PC1 [CD_W] = '{
        8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,
        8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18, 8'd10, 8'd2,
        8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
        8'd60, 8'd52, 8'd44, 8'd36, 8'd63, 8'd55, 8'd47, 8'd39,
        8'd31, 8'd23, 8'd15, 8'd7,  8'd62, 8'd54, 8'd46, 8'd38,
        8'd30, 8'd22, 8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37,
        8'd29, 8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
    };

    localparam byte unsigned PC2 [SUBKEY_W] = '{
        8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,  8'd3,  8'd28,
        8'd15, 8'd6,  8'd21, 8'd10, 8'd23, 8'd19, 8'd12, 8'd4,
        8'd26, 8'd8,  8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
        8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55, 8'd30, 8'd40,
        8'd51, 8'd45, 8'd33, 8'd48, 8'd44, 8'd49, 8'd39, 8'd56,
        8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
    };

    // set where the round rotates by two, round 1 leftmost
    localparam logic [0:ROUNDS-1] SHIFT_TWO = 16'b0011_1111_0111_1110;

    function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] key);
        logic [CD_W-1:0] res;
        res = '0;
        for (int k = 0; k < CD_W; k++) begin
            res[6'(CD_W - 1 - k)] = key[6'(KEY_W - int'(PC1[k]))];
        end
        return res;
    endfunction

    function automatic t_subkey pc2(input logic [CD_W-1:0] cd);
        t_subkey res;
        res = '0;
        for (int k = 0; k < SUBKEY_W; k++) begin
            res[6'(SUBKEY_W - 1 - k)] = cd[6'(CD_W - int'(PC2[k]))];
        end
        return res;
    endfunction

    function automatic t_half rotl(input t_half v, input logic two);
        return two ? {v[HALF_W-3:0], v[HALF_W-1:HALF_W-2]}
                   : {v[HALF_W-2:0], v[HALF_W-1]};
    endfunction

endpackage

`default_nettype wire

// ===== sv/des_key_schedule.sv =====
// ----------------------------------------------------------------------------
// DES key schedule
// Takes a 64-bit key and issues its sixteen round subkeys, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  key       in   i_key_valid / o_key_ready    i_key[63:0]
//  subkey    out  o_sub_valid / i_sub_ready    o_round_index, o_subkey, o_last
//
//  a key request loads PC-1 of the key into the C/D half registers
//  each following cycle rotates C/D once and registers PC-2 as a subkey
//  sixteen subkeys per key, one for each step of the single rotate stage on C/D
//  the next key is taken in the cycle the sixteenth subkey is registered
//  a stalled output holds C/D and the round count; reset empties both sides
// ----------------------------------------------------------------------------
`default_nettype none

module des_key_schedule (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_key_valid,
    output logic                               o_key_ready,
    input  wire logic [des_ks_pkg::KEY_W-1:0]  i_key,
    output logic                               o_sub_valid,
    input  wire logic                          i_sub_ready,
    output logic [des_ks_pkg::ROUND_W-1:0]     o_round_index,
    output logic [des_ks_pkg::SUBKEY_W-1:0]    o_subkey,
    output logic                               o_last
);

    logic                      r_busy;
    des_ks_pkg::t_half         r_c;
    des_ks_pkg::t_half         r_d;
    des_ks_pkg::t_round        r_round;

    logic                      r_out_valid;
    des_ks_pkg::t_round        r_out_round;
    des_ks_pkg::t_subkey       r_out_subkey;
    logic                      r_out_last;

    logic                      advance;
    logic                      final_round;
    logic                      key_take;
    des_ks_pkg::t_half         n_c;
    des_ks_pkg::t_half         n_d;
    logic [des_ks_pkg::CD_W-1:0] key_cd;

    assign advance     = r_busy && (!r_out_valid || i_sub_ready);
    assign final_round = (r_round == des_ks_pkg::t_round'(des_ks_pkg::ROUNDS - 1));
    assign o_key_ready = !r_busy || (advance && final_round);
    assign key_take    = i_key_valid && o_key_ready;

    assign n_c    = des_ks_pkg::rotl(r_c, des_ks_pkg::SHIFT_TWO[r_round]);
    assign n_d    = des_ks_pkg::rotl(r_d, des_ks_pkg::SHIFT_TWO[r_round]);
    assign key_cd = des_ks_pkg::pc1(i_key);

    // half registers and round count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= '0;
        end else if (key_take) begin
            r_busy  <= 1'b1;
            r_round <= '0;
        end else if (advance) begin
            r_busy  <= !final_round;
            r_round <= r_round + des_ks_pkg::t_round'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_take) begin
            r_c <= key_cd[des_ks_pkg::CD_W-1:des_ks_pkg::HALF_W];
            r_d <= key_cd[des_ks_pkg::HALF_W-1:0];
        end else if (advance) begin
            r_c <= n_c;
            r_d <= n_d;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_sub_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_round  <= r_round;
            r_out_subkey <= des_ks_pkg::pc2({n_c, n_d});
            r_out_last   <= final_round;
        end
    end

    assign o_sub_valid   = r_out_valid;
    assign o_round_index = r_out_round;
    assign o_subkey      = r_out_subkey;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire
